// ----- src/quaternion_to_euler_defines.svh -----
// Assertion macros used by the checker file
`ifndef QUATERNION_TO_EULER_DEFINES_SVH
`define QUATERNION_TO_EULER_DEFINES_SVH

// same-cycle implication
`define QTE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/qte_pkg.sv -----
// Types, constants and helper functions for the quaternion to Euler converter
`timescale 1ns / 1ps
package qte_pkg;

    localparam int IN_W              = 16;
    localparam int PROD_W            = 32;
    localparam int SUM_W             = 34;
    localparam int SQ_W              = 60;
    localparam int SQRT_BITS         = 29;
    localparam int CW                = 36;
    localparam int ANG_LEN           = 24;
    localparam int ANG_IDX_W         = 5;
    localparam int ROLL_W            = 16;
    localparam int PITCH_W           = 15;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam logic signed [SUM_W-1:0] ONE_Q28     = SUM_W'(64'sd268435456);
    localparam logic signed [CW-1:0]    PI_Q30      = CW'(64'sd3373259426);
    localparam logic signed [CW-1:0]    PI_Q13      = CW'(64'sd25736);
    localparam logic signed [CW-1:0]    HALF_PI_Q13 = CW'(64'sd12868);

    localparam logic [30:0] ATAN_TAB [ANG_LEN] = '{
        31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
        31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
        31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536,
        31'd32768, 31'd16384, 31'd8192, 31'd4096, 31'd2048,
        31'd1024, 31'd512, 31'd256, 31'd128
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 zero;
    } t_lane;

    function automatic logic signed [PROD_W-1:0] mul16(
        input logic signed [IN_W-1:0] a,
        input logic signed [IN_W-1:0] b
    );
        mul16 = PROD_W'(a) * PROD_W'(b);
    endfunction

    // fold the left half plane onto the right, start angle +/- pi
    function automatic t_lane cordic_init(
        input logic signed [SUM_W-1:0] num,
        input logic signed [SUM_W-1:0] den
    );
        t_lane l;
        l.zero = (num == '0) && (den == '0);
        if (den[SUM_W-1]) begin
            l.x = -CW'(den);
            l.y = -CW'(num);
            l.z = num[SUM_W-1] ? -PI_Q30 : PI_Q30;
        end else begin
            l.x = CW'(den);
            l.y = CW'(num);
            l.z = '0;
        end
        return l;
    endfunction

    function automatic t_lane cordic_step(input t_lane a, input logic [ANG_IDX_W-1:0] idx);
        t_lane                r;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [CW-1:0] at;
        xs = a.x >>> idx;
        ys = a.y >>> idx;
        at = CW'(ATAN_TAB[idx]);
        r.zero = a.zero;
        if (!a.y[CW-1]) begin
            r.x = a.x + ys;
            r.y = a.y - xs;
            r.z = a.z + at;
        end else begin
            r.x = a.x - ys;
            r.y = a.y + xs;
            r.z = a.z - at;
        end
        return r;
    endfunction

    // round to Q3.13 (floor of z + half lsb) and clamp to +/- lim
    function automatic logic signed [CW-1:0] ang_round(
        input t_lane                l,
        input logic signed [CW-1:0] lim
    );
        logic signed [CW-1:0] t;
        t = (l.z + (CW'(1) <<< 16)) >>> 17;
        if (l.zero)
            t = '0;
        else if (t > lim)
            t = lim;
        else if (t < -lim)
            t = -lim;
        return t;
    endfunction

endpackage

// ----- src/qte_in_if.sv -----
// Input channel: one quaternion word
`timescale 1ns / 1ps
interface qte_in_if;
    import qte_pkg::*;
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] quat_w;
    logic signed [IN_W-1:0] quat_x;
    logic signed [IN_W-1:0] quat_y;
    logic signed [IN_W-1:0] quat_z;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ----- src/qte_out_if.sv -----
// Output channel: one word of Euler angles
`timescale 1ns / 1ps
interface qte_out_if;
    import qte_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [ROLL_W-1:0]  roll_angle;
    logic signed [PITCH_W-1:0] pitch_angle;
    logic signed [ROLL_W-1:0]  yaw_angle;
    logic                      pitch_clamped;
    modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                    input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                    output ready);
endinterface

// ----- src/quaternion_to_euler.sv -----
// Quaternion to Z-Y-X Euler angle converter, fully pipelined
// Takes one Q1.14 quaternion word per cycle and returns roll and yaw in Q3.13
// and pitch in Q2.13 radians, one word per cycle while the output word is taken. Stages:
// products, sums, the pitch argument square, a 29-stage bit-per-stage square
// root for the pitch cosine, then three CORDIC lanes of CORDIC_STAGES stages
// in lock step and a rounding stage. Pitch saturates at +/- pi/2 and raises
// pitch_clamped when |2(wy-zx)| reaches one. When the output word is not taken
// the whole pipeline holds; nothing is lost or repeated.
`timescale 1ns / 1ps
module quaternion_to_euler #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qte_in_if.sink     i_in,
    qte_out_if.source  o_out
);
    import qte_pkg::*;

    typedef struct packed {
        logic signed [PROD_W-1:0] wx, yz, xx, yy, wz, xy, zz, wy, zx;
    } t_prod;

    typedef struct packed {
        logic signed [SUM_W-1:0] roll_num, roll_den, yaw_num, yaw_den, s;
        logic                    clamped;
    } t_sum;

    typedef struct packed {
        logic [SQ_W-1:0]      rem;
        logic [SQRT_BITS-1:0] root;
        t_sum                 sm;
    } t_sq;

    typedef struct packed {
        t_lane roll, pitch, yaw;
        logic  clamped;
        logic  s_pos;
    } t_cstg;

    logic en;

    logic  r_prod_vld;
    t_prod r_prod;
    logic  r_sum_vld;
    t_sum  r_sum;
    logic  r_sq_in_vld;
    t_sum  r_sq_in;
    logic [SQ_W-1:0] r_s_sq;

    logic r_sq_vld [SQRT_BITS+1];
    t_sq  r_sq     [SQRT_BITS+1];

    logic  r_cd_vld [CORDIC_STAGES+1];
    t_cstg r_cd     [CORDIC_STAGES+1];

    logic                      r_out_vld;
    logic signed [ROLL_W-1:0]  r_roll;
    logic signed [PITCH_W-1:0] r_pitch;
    logic signed [ROLL_W-1:0]  r_yaw;
    logic                      r_clamped;

    logic signed [CW-1:0] n_pitch;

    assign en          = !r_out_vld || o_out.ready;
    assign i_in.ready  = en;

    // products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else if (en) begin
            r_prod_vld <= i_in.valid;
        end
        if (en) begin
            r_prod.wx <= mul16(i_in.quat_w, i_in.quat_x);
            r_prod.yz <= mul16(i_in.quat_y, i_in.quat_z);
            r_prod.xx <= mul16(i_in.quat_x, i_in.quat_x);
            r_prod.yy <= mul16(i_in.quat_y, i_in.quat_y);
            r_prod.wz <= mul16(i_in.quat_w, i_in.quat_z);
            r_prod.xy <= mul16(i_in.quat_x, i_in.quat_y);
            r_prod.zz <= mul16(i_in.quat_z, i_in.quat_z);
            r_prod.wy <= mul16(i_in.quat_w, i_in.quat_y);
            r_prod.zx <= mul16(i_in.quat_z, i_in.quat_x);
        end
    end

    // numerators, denominators and the pitch argument at 2^28
    always_ff @(posedge i_clk) begin
        logic signed [SUM_W-1:0] s;
        s = (r_prod.wy - r_prod.zx) <<< 1;
        if (!i_rst_n) begin
            r_sum_vld <= 1'b0;
        end else if (en) begin
            r_sum_vld <= r_prod_vld;
        end
        if (en) begin
            r_sum.roll_num <= (r_prod.wx + r_prod.yz) <<< 1;
            r_sum.roll_den <= ONE_Q28 - ((r_prod.xx + r_prod.yy) <<< 1);
            r_sum.yaw_num  <= (r_prod.wz + r_prod.xy) <<< 1;
            r_sum.yaw_den  <= ONE_Q28 - ((r_prod.yy + r_prod.zz) <<< 1);
            r_sum.s        <= s;
            r_sum.clamped  <= (s >= ONE_Q28) || (s <= -ONE_Q28);
        end
    end

    // s^2; only meaningful when not clamped, so 29 bits of s suffice
    always_ff @(posedge i_clk) begin
        logic signed [SQRT_BITS-1:0] s29;
        logic [SQRT_BITS-2:0]        s_mag;
        s29   = r_sum.s[SQRT_BITS-1:0];
        s_mag = s29[SQRT_BITS-1] ? (SQRT_BITS-1)'(-s29) : s29[SQRT_BITS-2:0];
        if (!i_rst_n) begin
            r_sq_in_vld <= 1'b0;
        end else if (en) begin
            r_sq_in_vld <= r_sum_vld;
        end
        if (en) begin
            r_sq_in <= r_sum;
            r_s_sq  <= SQ_W'(s_mag) * SQ_W'(s_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (en) begin
            r_sq_vld[0] <= r_sq_in_vld;
        end
        if (en) begin
            r_sq[0].rem  <= (SQ_W'(1) << 56) - r_s_sq;
            r_sq[0].root <= '0;
            r_sq[0].sm   <= r_sq_in;
        end
    end

    // floor square root, one root bit per stage, MSB first
    for (genvar j = 1; j <= SQRT_BITS; j++) begin : g_sqrt
        localparam int K = SQRT_BITS - j;
        always_ff @(posedge i_clk) begin
            logic [SQ_W-1:0] test;
            test = (SQ_W'(r_sq[j-1].root) << (K + 1)) + (SQ_W'(1) << (2 * K));
            if (!i_rst_n) begin
                r_sq_vld[j] <= 1'b0;
            end else if (en) begin
                r_sq_vld[j] <= r_sq_vld[j-1];
            end
            if (en) begin
                r_sq[j].sm <= r_sq[j-1].sm;
                if (r_sq[j-1].rem >= test) begin
                    r_sq[j].rem  <= r_sq[j-1].rem - test;
                    r_sq[j].root <= r_sq[j-1].root | (SQRT_BITS'(1) << K);
                end else begin
                    r_sq[j].rem  <= r_sq[j-1].rem;
                    r_sq[j].root <= r_sq[j-1].root;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd_vld[0] <= 1'b0;
        end else if (en) begin
            r_cd_vld[0] <= r_sq_vld[SQRT_BITS];
        end
        if (en) begin
            r_cd[0].roll    <= cordic_init(r_sq[SQRT_BITS].sm.roll_num,
                                           r_sq[SQRT_BITS].sm.roll_den);
            r_cd[0].yaw     <= cordic_init(r_sq[SQRT_BITS].sm.yaw_num,
                                           r_sq[SQRT_BITS].sm.yaw_den);
            r_cd[0].pitch   <= cordic_init(r_sq[SQRT_BITS].sm.s,
                                           SUM_W'(r_sq[SQRT_BITS].root));
            r_cd[0].clamped <= r_sq[SQRT_BITS].sm.clamped;
            r_cd[0].s_pos   <= !r_sq[SQRT_BITS].sm.s[SUM_W-1];
        end
    end

    for (genvar i = 1; i <= CORDIC_STAGES; i++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cd_vld[i] <= 1'b0;
            end else if (en) begin
                r_cd_vld[i] <= r_cd_vld[i-1];
            end
            if (en) begin
                r_cd[i].roll    <= cordic_step(r_cd[i-1].roll, ANG_IDX_W'(i - 1));
                r_cd[i].pitch   <= cordic_step(r_cd[i-1].pitch, ANG_IDX_W'(i - 1));
                r_cd[i].yaw     <= cordic_step(r_cd[i-1].yaw, ANG_IDX_W'(i - 1));
                r_cd[i].clamped <= r_cd[i-1].clamped;
                r_cd[i].s_pos   <= r_cd[i-1].s_pos;
            end
        end
    end

    always_comb begin
        if (r_cd[CORDIC_STAGES].clamped)
            n_pitch = r_cd[CORDIC_STAGES].s_pos ? HALF_PI_Q13 : -HALF_PI_Q13;
        else
            n_pitch = ang_round(r_cd[CORDIC_STAGES].pitch, HALF_PI_Q13);
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_cd_vld[CORDIC_STAGES];
        end
        if (en) begin
            r_roll    <= ROLL_W'(ang_round(r_cd[CORDIC_STAGES].roll, PI_Q13));
            r_yaw     <= ROLL_W'(ang_round(r_cd[CORDIC_STAGES].yaw, PI_Q13));
            r_pitch   <= PITCH_W'(n_pitch);
            r_clamped <= r_cd[CORDIC_STAGES].clamped;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.roll_angle    = r_roll;
    assign o_out.pitch_angle   = r_pitch;
    assign o_out.yaw_angle     = r_yaw;
    assign o_out.pitch_clamped = r_clamped;

endmodule

// ----- src/qte_chk.sv -----
// Port-level checker for the quaternion to Euler converter, bound to the top level
`timescale 1ns / 1ps
`include "quaternion_to_euler_defines.svh"
module qte_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_roll,
    input logic signed [14:0] i_pitch,
    input logic signed [15:0] i_yaw,
    input logic               i_clamped
);
    // a saturated pitch is exactly +/- pi/2
    `QTE_ASSERT_NOW(a_clamp_val, i_clk, i_rst_n, i_out_valid && i_clamped, (i_pitch == 15'sd12868) || (i_pitch == -15'sd12868), "clamped pitch not at half pi")
    `QTE_ASSERT_NOW(a_ang_range, i_clk, i_rst_n, i_out_valid, (i_pitch <= 15'sd12868) && (i_pitch >= -15'sd12868) && (i_roll <= 16'sd25736) && (i_roll >= -16'sd25736) && (i_yaw <= 16'sd25736) && (i_yaw >= -16'sd25736), "angle out of range")
    // a waiting word stays and holds still
    `QTE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_roll) && $stable(i_pitch) && $stable(i_yaw) && $stable(i_clamped), "output word changed while stalled")
endmodule

bind quaternion_to_euler qte_chk u_qte_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_roll      (o_out.roll_angle),
    .i_pitch     (o_out.pitch_angle),
    .i_yaw       (o_out.yaw_angle),
    .i_clamped   (o_out.pitch_clamped)
);
